### design/utf8_validating_decoder_defines.svh
// Assertion macros for the decoder top-level file.
`ifndef UTF8_VALIDATING_DECODER_DEFINES_SVH
`define UTF8_VALIDATING_DECODER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define UVD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define UVD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/utf8vd_pkg.sv
`default_nettype none
package utf8vd_pkg;

	localparam int unsigned CP_W  = 21;
	localparam int unsigned LEN_W = 3;

	localparam logic [7:0] LEAD2_MIN = 8'hC2;
	localparam logic [7:0] LEAD2_MAX = 8'hDF;
	localparam logic [7:0] LEAD3_MIN = 8'hE0;
	localparam logic [7:0] LEAD3_MAX = 8'hEF;
	localparam logic [7:0] LEAD4_MIN = 8'hF0;
	localparam logic [7:0] LEAD4_MAX = 8'hF4;
	localparam logic [1:0] CONT_TAG  = 2'b10;

	localparam logic [CP_W-1:0] MIN_2    = 21'h00080;
	localparam logic [CP_W-1:0] MIN_3    = 21'h00800;
	localparam logic [CP_W-1:0] MIN_4    = 21'h10000;
	localparam logic [CP_W-1:0] CP_MAX   = 21'h10FFFF;
	localparam logic [CP_W-1:0] SURR_LO  = 21'h0D800;
	localparam logic [CP_W-1:0] SURR_HI  = 21'h0DFFF;

	localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
	localparam logic [LEN_W-1:0] LEN_1    = 3'd1;
	localparam logic [LEN_W-1:0] LEN_2    = 3'd2;
	localparam logic [LEN_W-1:0] LEN_3    = 3'd3;
	localparam logic [LEN_W-1:0] LEN_4    = 3'd4;

	typedef struct packed {
		logic [1:0]       bytes_left;
		logic [LEN_W-1:0] seq_length;
		logic [CP_W-1:0]  partial_point;
		logic             text_failed;
	} dec_state_t;

	typedef struct packed {
		logic [CP_W-1:0]  code_point;
		logic             point_ready;
		logic [LEN_W-1:0] point_length;
		logic             error_here;
		logic             text_done;
		logic             text_valid;
	} dec_result_t;

endpackage
`default_nettype wire

### design/utf8vd_step.sv
`default_nettype none
module utf8vd_step (
	input  wire utf8vd_pkg::dec_state_t  cur_state,
	input  wire logic [7:0]              data_byte,
	input  wire logic                    text_last,
	output utf8vd_pkg::dec_state_t       next_state,
	output utf8vd_pkg::dec_result_t      result
);
	import utf8vd_pkg::*;

	logic            err;
	logic [CP_W-1:0] acc;
	logic [CP_W-1:0] minimum;

	// bits gathered with this continuation byte appended
	assign acc = {cur_state.partial_point[CP_W-7:0], data_byte[5:0]};

	always_comb begin
		case (cur_state.seq_length)
			LEN_2:   minimum = MIN_2;
			LEN_3:   minimum = MIN_3;
			default: minimum = MIN_4;
		endcase
	end

	always_comb begin
		next_state = cur_state;
		result     = '0;
		err        = 1'b0;
		if (!cur_state.text_failed) begin
			if (cur_state.bytes_left == 2'd0) begin
				if (!data_byte[7]) begin
					result.code_point   = {{(CP_W-8){1'b0}}, data_byte};
					result.point_ready  = 1'b1;
					result.point_length = LEN_1;
				end else if (data_byte >= LEAD2_MIN && data_byte <= LEAD2_MAX) begin
					next_state.seq_length    = LEN_2;
					next_state.bytes_left    = 2'd1;
					next_state.partial_point = {{(CP_W-5){1'b0}}, data_byte[4:0]};
				end else if (data_byte >= LEAD3_MIN && data_byte <= LEAD3_MAX) begin
					next_state.seq_length    = LEN_3;
					next_state.bytes_left    = 2'd2;
					next_state.partial_point = {{(CP_W-4){1'b0}}, data_byte[3:0]};
				end else if (data_byte >= LEAD4_MIN && data_byte <= LEAD4_MAX) begin
					next_state.seq_length    = LEN_4;
					next_state.bytes_left    = 2'd3;
					next_state.partial_point = {{(CP_W-3){1'b0}}, data_byte[2:0]};
				end else begin
					err = 1'b1;
				end
			end else if (data_byte[7:6] != CONT_TAG) begin
				err = 1'b1;
			end else begin
				next_state.partial_point = acc;
				next_state.bytes_left    = cur_state.bytes_left - 2'd1;
				if (cur_state.bytes_left == 2'd1) begin
					// sequence complete: overlong, range and surrogate checks
					if (acc < minimum || acc > CP_MAX || (acc >= SURR_LO && acc <= SURR_HI)) begin
						err = 1'b1;
					end else begin
						result.code_point   = acc;
						result.point_ready  = 1'b1;
						result.point_length = cur_state.seq_length;
					end
					next_state.seq_length    = LEN_NONE;
					next_state.partial_point = '0;
				end
			end
			// text ends inside an open sequence
			if (!err && text_last && next_state.bytes_left != 2'd0) begin
				err = 1'b1;
			end
			if (err) begin
				next_state             = '0;
				next_state.text_failed = 1'b1;
			end
		end
		result.error_here = err;
		result.text_done  = text_last;
		result.text_valid = text_last && !next_state.text_failed;
		if (text_last) begin
			next_state = '0;
		end
	end

endmodule
`default_nettype wire

### design/utf8_validating_decoder.sv
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+-------------------------------------
//  data    | in        | data_valid / data_stall     | data_byte, text_last
//  result  | out       | result_valid / result_stall | code_point, point_ready, point_length,
//          |           |                             | error_here, text_done, text_valid
//
//  One byte per cycle while result_stall is low; one result per byte, via both registers.
//  The decode state is read and written in the same cycle a byte moves from the input
//  register into the result register, so that state loop sets the one-cycle rate.
//  Reset (arst_n low) empties both registers and clears the decode state.
//  A stall on the result side holds the result register; the input register still
//  takes a byte while empty, and data_stall rises only when both registers are full.
`default_nettype none
`include "utf8_validating_decoder_defines.svh"
module utf8_validating_decoder (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          data_valid,
	output logic                               data_stall,
	input  wire logic [7:0]                    data_byte,
	input  wire logic                          text_last,
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output logic [utf8vd_pkg::CP_W-1:0]        code_point,
	output logic                               point_ready,
	output logic [utf8vd_pkg::LEN_W-1:0]       point_length,
	output logic                               error_here,
	output logic                               text_done,
	output logic                               text_valid
);
	import utf8vd_pkg::*;

	// input register
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;

	// result register
	logic        valid_s2;
	dec_result_t result_s2;

	// decode state, updated on each advance into the result register
	dec_state_t  state_q;
	dec_state_t  state_next;
	dec_result_t result_next;

	logic in_xfer;
	logic advance;

	// result register is free when empty or being drained this cycle
	assign advance    = valid_s1 && (!valid_s2 || !result_stall);
	assign data_stall = valid_s1 && !advance;
	assign in_xfer    = data_valid && !data_stall;

	utf8vd_step u_step (
		.cur_state  (state_q),
		.data_byte  (byte_s1),
		.text_last  (last_s1),
		.next_state (state_next),
		.result     (result_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '0;
		end else begin
			// input stage: load on transfer, drop once moved on
			if (in_xfer) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			// result stage: hold under stall
			if (advance) begin
				valid_s2 <= 1'b1;
				state_q  <= state_next;
			end else if (!result_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			byte_s1 <= data_byte;
			last_s1 <= text_last;
		end
		if (advance) begin
			result_s2 <= result_next;
		end
	end

	assign result_valid = valid_s2;
	assign code_point   = result_s2.code_point;
	assign point_ready  = result_s2.point_ready;
	assign point_length = result_s2.point_length;
	assign error_here   = result_s2.error_here;
	assign text_done    = result_s2.text_done;
	assign text_valid   = result_s2.text_valid;

	// a text's last byte returns the decoder to its idle state
	`UVD_ASSERT_NEXT(a_clear_on_last, advance && last_s1, state_q == '0, "state not cleared after last byte")
	// an open sequence never coexists with a failed text
	`UVD_ASSERT_NOW(a_open_not_failed, state_q.bytes_left != 2'd0, !state_q.text_failed, "open sequence in failed text")
	// remaining count and sequence length agree on whether a sequence is open
	`UVD_ASSERT_NOW(a_len_matches, 1'b1, (state_q.bytes_left == 2'd0) == (state_q.seq_length == LEN_NONE), "sequence length and count disagree")
	// a stalled result keeps the decode state frozen
	`UVD_ASSERT_NEXT(a_state_hold, valid_s2 && result_stall, $stable(state_q), "state moved under result stall")

endmodule
`default_nettype wire
